// File: hdl/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared constants, sector codes and helpers for the HSV to RGB converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hsv2rgb_pkg;

  // floor(2^22 / 360); the quotient estimate is low by at most one
  localparam logic [13:0] RECIP_360   = 14'd11650;
  localparam int unsigned RECIP_SHIFT = 22;
  localparam logic [8:0]  HUE_CIRCLE  = 9'd360;
  localparam logic [7:0]  FULL_SCALE  = 8'd255;

  typedef enum logic [2:0] {
    SEC_RED_YEL  = 3'd0,
    SEC_YEL_GRN  = 3'd1,
    SEC_GRN_CYN  = 3'd2,
    SEC_CYN_BLU  = 3'd3,
    SEC_BLU_MAG  = 3'd4,
    SEC_MAG_RED  = 3'd5
  } sector_t;

  // Exact floor(x / 255) for any x up to 255 * 255, i.e. any product of two 8-bit values.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] sum;
    sum = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return sum[15:8];
  endfunction

endpackage

`default_nettype wire

// File: hdl/hsv2rgb_if.sv
// ----------------------------------------------------------------------------
// hsv2rgb_if
// Valid/ready channels for HSV input beats and RGB output beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsv2rgb_hsv_if;
  logic        valid;
  logic        ready;
  logic [15:0] hue;
  logic [7:0]  saturation;
  logic [7:0]  brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsv2rgb_rgb_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [23:0] packed_word;

  modport source (output valid, red, green, blue, packed_word, input ready);
  modport sink   (input valid, red, green, blue, packed_word, output ready);
endinterface

`default_nettype wire

// File: hdl/hsv_to_rgb_pixel_converter_core.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_pixel_converter_core
// Seven-stage pipelined HSV to 8-bit RGB / packed GRB pixel converter.
// ----------------------------------------------------------------------------
// Usage:
//   pix_in  (sink)   : one HSV pixel per beat: hue (degrees, any 16-bit
//                      value, wrapped mod 360), saturation, brightness.
//   pix_out (source) : one beat per pixel: red, green, blue and the same
//                      colour as packed_word = {green, red, blue}.
//   One beat per cycle sustained while pix_out.ready stays high: every
//   stage is one register, and the deepest path is the 16x14 reciprocal
//   multiply or the hue-wrap multiply-subtract.
//   Stages: 1 hue*recip(360), 2 wrap to 0..359, 3 sector and fraction,
//   4 products for p and the q/t scale terms, 5 divide by 255,
//   6 brightness products for q and t, 7 divide, sector select, output.
//   Each stage has its own valid bit and loads whenever it is empty or the
//   stage after it moves, so bubbles collapse and pix_in.ready stays high
//   while a finished pixel waits at the output as long as any stage is free.
//   When pix_out is stalled and all stages are full, pix_in.ready drops;
//   nothing is lost or repeated. Synchronous reset clears the valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_pixel_converter_core
  import hsv2rgb_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  hsv2rgb_hsv_if.sink        pix_in,
  hsv2rgb_rgb_if.source      pix_out
);

  localparam int unsigned Stages = 7;

  logic [Stages-1:0] vld;
  logic [Stages-1:0] en;

  // stage enable: load when empty or when the next stage takes our beat
  always_comb begin
    en[Stages-1] = !vld[Stages-1] || pix_out.ready;
    for (int i = Stages - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign pix_in.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= pix_in.valid;
      end
      for (int i = 1; i < Stages; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // ---- stage 1: quotient estimate of hue / 360 ----
  logic [15:0] hue1;
  logic [7:0]  quo1;
  logic [7:0]  sat1, val1;
  logic [29:0] recip_prod;

  assign recip_prod = {14'd0, pix_in.hue} * {16'd0, RECIP_360};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      hue1 <= pix_in.hue;
      quo1 <= recip_prod[29:RECIP_SHIFT];
      sat1 <= pix_in.saturation;
      val1 <= pix_in.brightness;
    end
  end

  // ---- stage 2: remainder, one correction step ----
  logic [16:0] quo_x360;
  logic [16:0] rem_raw;
  logic [16:0] rem_fix;
  logic [8:0]  hdeg2;
  logic [7:0]  sat2, val2;

  assign quo_x360 = {9'd0, quo1} * {8'd0, HUE_CIRCLE};
  assign rem_raw  = {1'b0, hue1} - quo_x360;
  assign rem_fix  = (rem_raw >= {8'd0, HUE_CIRCLE}) ? rem_raw - {8'd0, HUE_CIRCLE}
                                                    : rem_raw;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      hdeg2 <= rem_fix[8:0];
      sat2  <= sat1;
      val2  <= val1;
    end
  end

  // ---- stage 3: sector and fraction = (h mod 60) * 17 / 4 ----
  sector_t     sector_c;
  logic [8:0]  base_c;
  logic [5:0]  hmod_c;
  logic [9:0]  frac_x4;
  sector_t     sector3;
  logic [7:0]  frac3;
  logic [7:0]  sat3, val3;

  always_comb begin
    if (hdeg2 >= 9'd300) begin
      sector_c = SEC_MAG_RED; base_c = 9'd300;
    end else if (hdeg2 >= 9'd240) begin
      sector_c = SEC_BLU_MAG; base_c = 9'd240;
    end else if (hdeg2 >= 9'd180) begin
      sector_c = SEC_CYN_BLU; base_c = 9'd180;
    end else if (hdeg2 >= 9'd120) begin
      sector_c = SEC_GRN_CYN; base_c = 9'd120;
    end else if (hdeg2 >= 9'd60) begin
      sector_c = SEC_YEL_GRN; base_c = 9'd60;
    end else begin
      sector_c = SEC_RED_YEL; base_c = 9'd0;
    end
  end

  assign hmod_c  = 6'(hdeg2 - base_c);
  assign frac_x4 = {hmod_c, 4'd0} + {4'd0, hmod_c};

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sector3 <= sector_c;
      frac3   <= frac_x4[9:2];
      sat3    <= sat2;
      val3    <= val2;
    end
  end

  // ---- stage 4: p numerator and q/t scale products ----
  logic [15:0] pnum4, qsc4, tsc4;
  sector_t     sector4;
  logic        gray4;
  logic [7:0]  val4;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      pnum4   <= {8'd0, val3} * {8'd0, FULL_SCALE - sat3};
      qsc4    <= {8'd0, sat3} * {8'd0, frac3};
      tsc4    <= {8'd0, sat3} * {8'd0, FULL_SCALE - frac3};
      sector4 <= sector3;
      gray4   <= (sat3 == 8'd0);
      val4    <= val3;
    end
  end

  // ---- stage 5: divide by 255 ----
  logic [7:0]  p5, qf5, tf5;
  sector_t     sector5;
  logic        gray5;
  logic [7:0]  val5;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      p5      <= div255(pnum4);
      qf5     <= FULL_SCALE - div255(qsc4);
      tf5     <= FULL_SCALE - div255(tsc4);
      sector5 <= sector4;
      gray5   <= gray4;
      val5    <= val4;
    end
  end

  // ---- stage 6: brightness products for q and t ----
  logic [15:0] qnum6, tnum6;
  logic [7:0]  p6;
  sector_t     sector6;
  logic        gray6;
  logic [7:0]  val6;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      qnum6   <= {8'd0, val5} * {8'd0, qf5};
      tnum6   <= {8'd0, val5} * {8'd0, tf5};
      p6      <= p5;
      sector6 <= sector5;
      gray6   <= gray5;
      val6    <= val5;
    end
  end

  // ---- stage 7: final divide, sector routing, output register ----
  logic [7:0] q_c, t_c;
  logic [7:0] r_c, g_c, b_c;
  logic [7:0] red7, green7, blue7;

  assign q_c = div255(qnum6);
  assign t_c = div255(tnum6);

  always_comb begin
    if (gray6) begin
      r_c = val6; g_c = val6; b_c = val6;
    end else begin
      case (sector6)
        SEC_RED_YEL: begin r_c = val6; g_c = t_c;  b_c = p6;   end
        SEC_YEL_GRN: begin r_c = q_c;  g_c = val6; b_c = p6;   end
        SEC_GRN_CYN: begin r_c = p6;   g_c = val6; b_c = t_c;  end
        SEC_CYN_BLU: begin r_c = p6;   g_c = q_c;  b_c = val6; end
        SEC_BLU_MAG: begin r_c = t_c;  g_c = p6;   b_c = val6; end
        default:     begin r_c = val6; g_c = p6;   b_c = q_c;  end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      red7   <= r_c;
      green7 <= g_c;
      blue7  <= b_c;
    end
  end

  assign pix_out.valid       = vld[Stages-1];
  assign pix_out.red         = red7;
  assign pix_out.green       = green7;
  assign pix_out.blue        = blue7;
  assign pix_out.packed_word = {green7, red7, blue7};

  // ---- assertions ----
  a_wrap_range: assert property (@(posedge clk) disable iff (rst)
    vld[1] |-> hdeg2 < HUE_CIRCLE)
    else $error("hue wrap left 0..359");

  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    vld[2] |-> frac3 <= 8'd250)
    else $error("sector fraction above 250");

  a_empty_tail_ready: assert property (@(posedge clk) disable iff (rst)
    !vld[Stages-1] |-> pix_in.ready)
    else $error("input stalled with empty output stage");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (&vld && !pix_out.ready) |-> !pix_in.ready)
    else $error("input taken while pipeline full and stalled");

  a_no_invented_beats: assert property (@(posedge clk) disable iff (rst)
    !(pix_in.valid && pix_in.ready) |=> $countones(vld) <= $past($countones(vld)))
    else $error("beat count grew without an accepted beat");

endmodule

`default_nettype wire
